// ===== rtl/lpcp_pkg.sv =====
package lpcp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd6;

  localparam logic [47:0] ROT0_RST   = 48'h0000_4000_0000;
  localparam logic [47:0] ROT1_RST   = 48'h0000_0000_4000;
  localparam logic [47:0] ROT2_RST   = 48'h0;
  localparam logic [59:0] TRANS_RST  = 60'h0;
  localparam logic [63:0] INTR_RST   = 64'h0;
  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  localparam int MARGIN_CELL_DEF = 5;
  localparam logic [12:0] MAX_SIDE = 13'd4096;

  localparam int CAM_W  = 38;  // camera coordinate, mm * 2^14
  localparam int NUM_W  = 56;  // projected numerator
  localparam int DEN_W  = 43;  // signed depth * 16
  localparam int REM_W  = 54;  // divider remainder
  localparam int PIX_W  = 12;
  localparam int SIDE_W = 13;
  localparam int LIM_W  = 14;
  localparam int MRG_W  = 6;

  typedef struct packed {
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic [7:0]         intensity;
    logic               point_valid;
  } point_t;

  typedef struct packed {
    logic             in_view;
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
    logic [7:0]       color_red;
    logic [7:0]       color_green;
    logic [7:0]       color_blue;
  } result_t;

  typedef struct packed {
    logic        pre_view;
    logic [23:0] color;
  } side_t;

  typedef logic [23:0] color_lut_t [256];

  function automatic color_lut_t build_color_lut();
    color_lut_t lut;
    int x, nr, ng, nb;
    for (x = 0; x < 256; x++) begin
      if (x <= 63) begin
        nr = 76500 + 400 * x; ng = 0; nb = 204000 - 200 * x;
      end else if (x <= 127) begin
        nr = 223125 - 700 * x; ng = 200 * x - 12750; nb = 127500 + 400 * x;
      end else if (x <= 191) begin
        nr = 0; ng = 800 * x - 51000; nb = 318750 - 500 * x;
      end else begin
        nr = 200 * x - 38250; ng = 255000; nb = 223125 - 500 * x;
      end
      lut[x] = {8'((nr / 1000) % 256), 8'((ng / 1000) % 256), 8'((nb / 1000) % 256)};
    end
    return lut;
  endfunction

  localparam color_lut_t COLOR_LUT = build_color_lut();

endpackage

// ===== rtl/lpcp_margin.sv =====
module lpcp_margin #(
  parameter int MARGIN_CELL = lpcp_pkg::MARGIN_CELL_DEF
) (
  input  logic                               clk,
  input  logic [lpcp_pkg::SIDE_W-1:0]        side_raw,
  output logic [lpcp_pkg::MRG_W-1:0]         margin_r,
  output logic signed [lpcp_pkg::LIM_W-1:0]  limit_r
);

  localparam int SH = 24;
  localparam longint unsigned RECIP = (64'd1 << SH) / MARGIN_CELL;
  localparam logic [7:0] MC = 8'(MARGIN_CELL);

  logic [lpcp_pkg::SIDE_W-1:0] s_a_r, s_b_r;
  logic [lpcp_pkg::SIDE_W-1:0] q_r;
  logic [7:0]                  rem_r;
  logic [37:0]                 prod;
  logic [20:0]                 back;
  logic [7:0]                  rem_c;
  logic [lpcp_pkg::SIDE_W-1:0] s_clamp;

  always_comb begin
    s_clamp = (side_raw > lpcp_pkg::MAX_SIDE) ? lpcp_pkg::MAX_SIDE : side_raw;
    prod    = 38'(s_clamp) * 38'(RECIP[24:0]);
    back    = 21'(q_r) * 21'(MC);
    rem_c   = (rem_r >= MC) ? rem_r - MC : rem_r;
  end

  // quotient may come out one short; the remainder step fixes it
  always_ff @(posedge clk) begin
    s_a_r    <= s_clamp;
    q_r      <= prod[SH +: lpcp_pkg::SIDE_W];
    s_b_r    <= s_a_r;
    rem_r    <= 8'(21'(s_a_r) - back);
    margin_r <= lpcp_pkg::MRG_W'(rem_c[7:1]) + 1'b1;
    limit_r  <= $signed({1'b0, s_b_r}) - $signed(lpcp_pkg::LIM_W'(rem_c[7:1]) + 14'd1);
  end

endmodule

// ===== rtl/lpcp_xform.sv =====
module lpcp_xform (
  input  logic                                clk,
  input  logic                                en1,
  input  logic                                en2,
  input  lpcp_pkg::point_t                    point,
  input  logic [47:0]                         rot_row [3],
  input  logic [59:0]                         trans,
  output logic signed [lpcp_pkg::CAM_W-1:0]   cam_r [3]
);

  logic signed [35:0] prod_r [3][3];
  logic signed [33:0] tofs_r [3];
  logic signed [19:0] p [3];

  assign p[0] = point.point_x;
  assign p[1] = point.point_y;
  assign p[2] = point.point_z;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        tofs_r[i] <= {$signed(trans[59-20*i -: 20]), 14'd0};
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= $signed(rot_row[i][47-16*j -: 16]) * p[j];
        end
      end
    end
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        cam_r[i] <= lpcp_pkg::CAM_W'(tofs_r[i]) + lpcp_pkg::CAM_W'(prod_r[i][0])
                  + lpcp_pkg::CAM_W'(prod_r[i][1]) + lpcp_pkg::CAM_W'(prod_r[i][2]);
      end
    end
  end

endmodule

// ===== rtl/lpcp_proj.sv =====
module lpcp_proj (
  input  logic                                clk,
  input  logic                                en3,
  input  logic                                en4,
  input  logic                                en5,
  input  logic signed [lpcp_pkg::CAM_W-1:0]   cam [3],
  input  logic [63:0]                         intr,
  output logic [lpcp_pkg::REM_W-1:0]          num_u_r,
  output logic [lpcp_pkg::REM_W-1:0]          num_v_r,
  output logic [lpcp_pkg::DEN_W-2:0]          den_r,
  output logic                                ok_r
);

  localparam int NW = lpcp_pkg::NUM_W;
  localparam int DW = lpcp_pkg::DEN_W;

  logic signed [54:0] mfx_r, mcx_r, mfy_r, mcy_r;
  logic signed [lpcp_pkg::CAM_W-1:0] zc3_r;
  logic signed [NW-1:0] nu4_r, nv4_r;
  logic signed [DW-1:0] d4_r;
  logic signed [NW-1:0] su, sv;
  logic [NW+11:0] lim;

  always_comb begin
    su  = NW'(mfx_r) + NW'(mcx_r);
    sv  = NW'(mfy_r) + NW'(mcy_r);
    lim = {(NW)'(d4_r), 12'd0};
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mfx_r <= $signed({1'b0, intr[63:48]}) * cam[0];
      mcx_r <= $signed({1'b0, intr[31:16]}) * cam[2];
      mfy_r <= $signed({1'b0, intr[47:32]}) * cam[1];
      mcy_r <= $signed({1'b0, intr[15:0]}) * cam[2];
      zc3_r <= cam[2];
    end
    // flip signs so the divisor is positive; floor is unchanged
    if (en4) begin
      nu4_r <= zc3_r[lpcp_pkg::CAM_W-1] ? -su : su;
      nv4_r <= zc3_r[lpcp_pkg::CAM_W-1] ? -sv : sv;
      d4_r  <= zc3_r[lpcp_pkg::CAM_W-1] ? -(DW'(zc3_r) <<< 4) : (DW'(zc3_r) <<< 4);
    end
    if (en5) begin
      num_u_r <= nu4_r[lpcp_pkg::REM_W-1:0];
      num_v_r <= nv4_r[lpcp_pkg::REM_W-1:0];
      den_r   <= d4_r[DW-2:0];
      ok_r    <= !nu4_r[NW-1] && !nv4_r[NW-1]
                 && ((NW+12)'(nu4_r) < lim) && ((NW+12)'(nv4_r) < lim);
    end
  end

endmodule

// ===== rtl/lpcp_div.sv =====
module lpcp_div (
  input  logic                               clk,
  input  logic [lpcp_pkg::PIX_W-1:0]         en,
  input  logic [lpcp_pkg::REM_W-1:0]         num,
  input  logic [lpcp_pkg::DEN_W-2:0]         den,
  output logic [lpcp_pkg::PIX_W-1:0]         quo
);

  localparam int QW = lpcp_pkg::PIX_W;
  localparam int RW = lpcp_pkg::REM_W;

  logic [RW-1:0]                  rem_r [QW];
  logic [lpcp_pkg::DEN_W-2:0]     den_r [QW];
  logic [QW-1:0]                  q_r   [QW];
  logic [RW-1:0]                  rem_in [QW];
  logic [lpcp_pkg::DEN_W-2:0]     den_in [QW];
  logic [QW-1:0]                  q_in   [QW];
  logic [RW-1:0]                  shd    [QW];

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      rem_in[k] = (k == 0) ? num : rem_r[(k == 0) ? 0 : k-1];
      den_in[k] = (k == 0) ? den : den_r[(k == 0) ? 0 : k-1];
      q_in[k]   = (k == 0) ? '0  : q_r[(k == 0) ? 0 : k-1];
      shd[k]    = RW'(den_in[k]) << (QW-1-k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (en[k]) begin
        den_r[k] <= den_in[k];
        if (rem_in[k] >= shd[k]) begin
          rem_r[k] <= rem_in[k] - shd[k];
          q_r[k]   <= q_in[k] | (QW'(1) << (QW-1-k));
        end else begin
          rem_r[k] <= rem_in[k];
          q_r[k]   <= q_in[k];
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== rtl/lidar_point_camera_projector.sv =====
// Lidar point to camera pixel projector.
// Input channel in_valid/in_ready/in_data carries one lidar point per
// transfer; the result channel out_valid/out_ready/out_data returns one
// result per point, in order. Configuration goes through cfg_valid/cfg_ready
// (always ready) with cfg_index selecting the register and cfg_data the value;
// write only while no point is in flight.
// From input transfer to out_valid a point passes two stages of rotation,
// three of projection and sign handling, twelve of the pipelined restoring
// divider (one quotient bit per stage) and one output register; the
// divider stages set the depth. Throughput is one point per cycle while
// out_ready is high. Every stage holds its own valid bit, so when the
// receiver stalls, bubbles collapse and in_ready drops only once every
// stage holds a point. Synchronous reset (rst_n low) empties the pipeline
// and loads the register defaults; image margins follow a register write.
module lidar_point_camera_projector #(
  parameter int MARGIN_CELL = lpcp_pkg::MARGIN_CELL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpcp_pkg::point_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lpcp_pkg::result_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NS = 18;
  localparam int QW = lpcp_pkg::PIX_W;

  logic [47:0] rot_r [3];
  logic [59:0] trans_r;
  logic [63:0] intr_r;
  logic [12:0] width_r, height_r;

  logic [NS:1]   v_r;
  logic [NS:1]   v_in;
  logic [NS+1:1] en;
  lpcp_pkg::side_t side_r [1:NS-1];
  lpcp_pkg::result_t out_r;

  logic signed [lpcp_pkg::CAM_W-1:0] cam [3];
  logic [lpcp_pkg::REM_W-1:0] num_u, num_v;
  logic [lpcp_pkg::DEN_W-2:0] den;
  logic ok;
  logic [QW-1:0] qu, qv;
  logic [lpcp_pkg::MRG_W-1:0] mw, mh;
  logic signed [lpcp_pkg::LIM_W-1:0] lw, lh;
  logic view;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= lpcp_pkg::ROT0_RST;
      rot_r[1] <= lpcp_pkg::ROT1_RST;
      rot_r[2] <= lpcp_pkg::ROT2_RST;
      trans_r  <= lpcp_pkg::TRANS_RST;
      intr_r   <= lpcp_pkg::INTR_RST;
      width_r  <= lpcp_pkg::WIDTH_RST;
      height_r <= lpcp_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lpcp_pkg::CFG_ROT0:   rot_r[0] <= cfg_data[47:0];
        lpcp_pkg::CFG_ROT1:   rot_r[1] <= cfg_data[47:0];
        lpcp_pkg::CFG_ROT2:   rot_r[2] <= cfg_data[47:0];
        lpcp_pkg::CFG_TRANS:  trans_r  <= cfg_data[59:0];
        lpcp_pkg::CFG_INTR:   intr_r   <= cfg_data;
        lpcp_pkg::CFG_WIDTH:  width_r  <= cfg_data[12:0];
        lpcp_pkg::CFG_HEIGHT: height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_in      = {v_r[NS-1:1], in_valid};
  assign in_ready  = en[1];
  assign out_valid = v_r[NS];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1].pre_view <= in_data.point_valid && !in_data.point_x[19];
      side_r[1].color    <= lpcp_pkg::COLOR_LUT[in_data.intensity];
    end
    for (int k = 2; k < NS; k++) begin
      if (en[k]) begin
        side_r[k].color <= side_r[k-1].color;
        if (k == 3) side_r[k].pre_view <= side_r[k-1].pre_view && (cam[2] != '0);
        else if (k == 6) side_r[k].pre_view <= side_r[k-1].pre_view && ok;
        else side_r[k].pre_view <= side_r[k-1].pre_view;
      end
    end
  end

  lpcp_xform u_xform (
    .clk     (clk),
    .en1     (en[1]),
    .en2     (en[2]),
    .point   (in_data),
    .rot_row (rot_r),
    .trans   (trans_r),
    .cam_r   (cam)
  );

  lpcp_proj u_proj (
    .clk     (clk),
    .en3     (en[3]),
    .en4     (en[4]),
    .en5     (en[5]),
    .cam     (cam),
    .intr    (intr_r),
    .num_u_r (num_u),
    .num_v_r (num_v),
    .den_r   (den),
    .ok_r    (ok)
  );

  lpcp_div u_div_u (
    .clk (clk),
    .en  (en[17:6]),
    .num (num_u),
    .den (den),
    .quo (qu)
  );

  lpcp_div u_div_v (
    .clk (clk),
    .en  (en[17:6]),
    .num (num_v),
    .den (den),
    .quo (qv)
  );

  lpcp_margin #(.MARGIN_CELL(MARGIN_CELL)) u_margin_w (
    .clk      (clk),
    .side_raw (width_r),
    .margin_r (mw),
    .limit_r  (lw)
  );

  lpcp_margin #(.MARGIN_CELL(MARGIN_CELL)) u_margin_h (
    .clk      (clk),
    .side_raw (height_r),
    .margin_r (mh),
    .limit_r  (lh)
  );

  always_comb begin
    view = side_r[NS-1].pre_view
           && (qu >= QW'(mw)) && ($signed({2'b00, qu}) < lw)
           && (qv >= QW'(mh)) && ($signed({2'b00, qv}) < lh);
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      out_r.in_view     <= view;
      out_r.pixel_u     <= view ? qu : '0;
      out_r.pixel_v     <= view ? qv : '0;
      out_r.color_red   <= side_r[NS-1].color[23:16];
      out_r.color_green <= side_r[NS-1].color[15:8];
      out_r.color_blue  <= side_r[NS-1].color[7:0];
    end
  end

  a_hidden_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_view) |-> (out_data.pixel_u == '0 && out_data.pixel_v == '0))
    else $error("pixel not cleared for point out of view");

  a_u_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_view) |-> (out_data.pixel_u >= QW'(mw)
      && $signed({2'b00, out_data.pixel_u}) < lw))
    else $error("column outside window");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[1] |-> in_ready)
    else $error("input stalled with empty first stage");

endmodule
